// ===== hdl/stct_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and types for the sample triple count table
// no dependencies

package stct_pkg;

  localparam int SLOTS_DEF  = 4096;
  localparam int MAX_PROBES = 32;

  localparam int PROBE_W = 6;
  localparam int FILL_W  = 13;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_B = 32'd2246822519;

  localparam logic [PROBE_W-1:0] PROBE_LIMIT_RST = 6'd32;
  localparam logic [FILL_W-1:0]  FILL_LIMIT_RST  = 13'd3072;

  typedef logic [1:0] status_t;
  localparam status_t ST_COUNTED = 2'd0;
  localparam status_t ST_NEW     = 2'd1;
  localparam status_t ST_DROPPED = 2'd2;
  localparam status_t ST_READ    = 2'd3;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_PROBE_LIMIT = 1'b0;
  localparam reg_idx_t REG_FILL_LIMIT  = 1'b1;

  typedef struct packed {
    logic [PROBE_W-1:0] probe_limit;
    logic [FILL_W-1:0]  fill_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] thread;
    logic [31:0] caller;
    logic [31:0] address;
    logic [31:0] count;
  } row_t;

endpackage

// ===== hdl/stct_in_if.sv =====
`timescale 1ns / 1ps
// input channel: record or read item with valid/ready handshake
// no dependencies

interface stct_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] address;
  logic [31:0] caller;
  logic [31:0] thread;
  logic [11:0] slot_index;

  modport source (output valid, operation, address, caller, thread, slot_index,
                  input ready);
  modport sink   (input valid, operation, address, caller, thread, slot_index,
                  output ready);
endinterface

// ===== hdl/stct_out_if.sv =====
`timescale 1ns / 1ps
// result channel: one result item per input item, valid/ready handshake
// no dependencies

interface stct_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] entry_address;
  logic [31:0] entry_caller;
  logic [31:0] entry_thread;
  logic [31:0] entry_count;
  logic [31:0] total_samples;
  logic [31:0] total_dropped;

  modport source (output valid, status, entry_address, entry_caller, entry_thread,
                  entry_count, total_samples, total_dropped, input ready);
  modport sink   (input valid, status, entry_address, entry_caller, entry_thread,
                  entry_count, total_samples, total_dropped, output ready);
endinterface

// ===== hdl/stct_cfg.sv =====
`timescale 1ns / 1ps
// apb-style register block: probe limit and fill limit
// depends on stct_pkg

module stct_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stct_pkg::CFG_AW-1:0] paddr,
  input  logic [stct_pkg::CFG_DW-1:0] pwdata,
  output logic [stct_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output stct_pkg::cfg_t              cfg
);
  import stct_pkg::*;

  logic [PROBE_W-1:0] probe_limit_r;
  logic [FILL_W-1:0]  fill_limit_r;
  reg_idx_t           reg_idx;
  logic               wr_en;

  // registers sit on 4-byte boundaries, low address bits ignored
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_limit_r <= PROBE_LIMIT_RST;
      fill_limit_r  <= FILL_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PROBE_LIMIT: probe_limit_r <= pwdata[PROBE_W-1:0];
        REG_FILL_LIMIT:  fill_limit_r  <= pwdata[FILL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PROBE_LIMIT: prdata = CFG_DW'(probe_limit_r);
      REG_FILL_LIMIT:  prdata = CFG_DW'(fill_limit_r);
    endcase
  end

  assign cfg.probe_limit = probe_limit_r;
  assign cfg.fill_limit  = fill_limit_r;

endmodule

// ===== hdl/stct_mul.sv =====
`timescale 1ns / 1ps
// shared 32x32 multiplier for the hash, low half of the product registered
// no dependencies

module stct_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [31:0] p_r;

  // wrapping product, only the low 32 bits are kept
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/stct_store.sv =====
`timescale 1ns / 1ps
// slot memory: one row per slot holding triple and count, registered read
// depends on stct_pkg

module stct_store #(
  parameter int SLOTS = stct_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     re,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output stct_pkg::row_t           rdata,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  stct_pkg::row_t           wdata
);
  import stct_pkg::*;

  row_t mem_r [SLOTS];
  row_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/stct_seq.sv =====
`timescale 1ns / 1ps
// sequencer: clear pass, hash through the shared multiplier, linear probe,
// slot update, totals and the result register
// depends on stct_pkg

module stct_seq #(
  parameter int SLOTS = stct_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stct_pkg::cfg_t           cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_operation,
  input  logic [31:0]              in_address,
  input  logic [31:0]              in_caller,
  input  logic [31:0]              in_thread,
  input  logic [11:0]              in_slot_index,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stct_pkg::status_t        out_status,
  output logic [31:0]              out_entry_address,
  output logic [31:0]              out_entry_caller,
  output logic [31:0]              out_entry_thread,
  output logic [31:0]              out_entry_count,
  output logic [31:0]              out_total_samples,
  output logic [31:0]              out_total_dropped,
  output logic                     mul_en,
  output logic [31:0]              mul_a,
  output logic [31:0]              mul_b,
  input  logic [31:0]              mul_p,
  output logic                     mem_re,
  output logic [$clog2(SLOTS)-1:0] mem_raddr,
  input  stct_pkg::row_t           mem_rdata,
  output logic                     mem_we,
  output logic [$clog2(SLOTS)-1:0] mem_waddr,
  output stct_pkg::row_t           mem_wdata
);
  import stct_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IU_W   = $clog2(SLOTS + 1);
  localparam int CMP_W  = (IU_W > FILL_W) ? IU_W : FILL_W;
  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(SLOTS - 1);
  localparam logic [PROBE_W-1:0] PROBE_MAX = PROBE_W'(MAX_PROBES);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH_A = 4'd2;
  localparam logic [3:0] S_HASH_B = 4'd3;
  localparam logic [3:0] S_HASH_C = 4'd4;
  localparam logic [3:0] S_PROBE  = 4'd5;
  localparam logic [3:0] S_RD_ISS = 4'd6;
  localparam logic [3:0] S_RD_CAP = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  // control
  logic [3:0]         state_r;
  logic [SLOT_W-1:0]  clr_cnt_r;
  logic [PROBE_W-1:0] iss_cnt_r;
  logic [PROBE_W-1:0] chk_cnt_r;
  logic               pend_r;
  logic               out_valid_r;
  logic [IU_W-1:0]    inuse_r;
  logic [31:0]        samples_r;
  logic [31:0]        dropped_r;

  // payload
  logic [31:0]        addr_r;
  logic [31:0]        call_r;
  logic [31:0]        thr_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [SLOT_W-1:0]  base_r;
  logic [PROBE_W-1:0] probes_r;
  logic [SLOT_W-1:0]  slot_r;
  row_t               row_r;
  status_t            st_r;
  status_t            out_status_r;
  logic [31:0]        out_addr_r;
  logic [31:0]        out_call_r;
  logic [31:0]        out_thr_r;
  logic [31:0]        out_cnt_r;
  logic [31:0]        out_samples_r;
  logic [31:0]        out_dropped_r;

  logic               accept;
  logic               issue;
  logic [SLOT_W-1:0]  probe_slot;
  logic [SLOT_W-1:0]  chk_slot;
  logic               slot_empty;
  logic               slot_match;
  logic               table_full;
  logic               last_probe;
  logic               probe_done;
  status_t            probe_st;
  logic               fin_go;
  logic [31:0]        cnt_inc;
  logic [31:0]        samples_nxt;
  logic [31:0]        dropped_nxt;
  logic [PROBE_W-1:0] probes_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign probes_nxt = (cfg.probe_limit > PROBE_MAX) ? PROBE_MAX : cfg.probe_limit;

  // shared multiplier: address product first, caller product second
  assign mul_en = (state_r == S_HASH_A) || (state_r == S_HASH_B);
  assign mul_a  = (state_r == S_HASH_B) ? call_r : addr_r;
  assign mul_b  = (state_r == S_HASH_B) ? HASH_MUL_B : HASH_MUL_A;

  // one read issued per cycle, its data checked in the cycle after
  assign issue      = (state_r == S_PROBE) && (iss_cnt_r < probes_r);
  assign probe_slot = base_r + SLOT_W'(iss_cnt_r);
  assign chk_slot   = base_r + SLOT_W'(chk_cnt_r);

  assign mem_re    = issue || (state_r == S_RD_ISS);
  assign mem_raddr = (state_r == S_RD_ISS) ? idx_r : probe_slot;

  assign slot_empty = (mem_rdata.count == 32'd0);
  assign slot_match = (mem_rdata.address == addr_r) && (mem_rdata.caller == call_r) &&
                      (mem_rdata.thread == thr_r);
  assign table_full = CMP_W'(inuse_r) >= CMP_W'(cfg.fill_limit);
  assign last_probe = (chk_cnt_r == probes_r - PROBE_W'(1));
  assign probe_done = (state_r == S_PROBE) && pend_r &&
                      (slot_empty || slot_match || last_probe);

  always_comb begin
    priority if (slot_empty) begin
      probe_st = table_full ? ST_DROPPED : ST_NEW;
    end else if (slot_match) begin
      probe_st = ST_COUNTED;
    end else begin
      probe_st = ST_DROPPED;
    end
  end

  // result register must be free before the slot and totals update
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_ready);

  assign cnt_inc     = (&row_r.count) ? row_r.count : row_r.count + 32'd1;
  assign samples_nxt = ((st_r == ST_NEW) || (st_r == ST_COUNTED)) && !(&samples_r) ?
                       samples_r + 32'd1 : samples_r;
  assign dropped_nxt = (st_r == ST_DROPPED) && !(&dropped_r) ?
                       dropped_r + 32'd1 : dropped_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = row_r;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (fin_go && (st_r == ST_NEW)) begin
      mem_we            = 1'b1;
      mem_wdata.thread  = thr_r;
      mem_wdata.caller  = call_r;
      mem_wdata.address = addr_r;
      mem_wdata.count   = 32'd1;
    end else if (fin_go && (st_r == ST_COUNTED)) begin
      mem_we          = 1'b1;
      mem_wdata.count = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      iss_cnt_r   <= '0;
      chk_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      inuse_r     <= '0;
      samples_r   <= '0;
      dropped_r   <= '0;
    end else begin
      pend_r <= issue;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + SLOT_W'(1);
          if (clr_cnt_r == SLOT_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= in_operation ? S_RD_ISS : S_HASH_A;
          end
        end
        S_HASH_A: state_r <= S_HASH_B;
        S_HASH_B: state_r <= S_HASH_C;
        S_HASH_C: begin
          iss_cnt_r <= '0;
          chk_cnt_r <= '0;
          state_r   <= (probes_r == '0) ? S_FIN : S_PROBE;
        end
        S_PROBE: begin
          if (issue) begin
            iss_cnt_r <= iss_cnt_r + PROBE_W'(1);
          end
          if (probe_done) begin
            state_r <= S_FIN;
          end else if (pend_r) begin
            chk_cnt_r <= chk_cnt_r + PROBE_W'(1);
          end
        end
        S_RD_ISS: state_r <= S_RD_CAP;
        S_RD_CAP: state_r <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            samples_r   <= samples_nxt;
            dropped_r   <= dropped_nxt;
            inuse_r     <= inuse_r + IU_W'(st_r == ST_NEW);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r   <= in_address;
      call_r   <= in_caller;
      thr_r    <= in_thread;
      idx_r    <= SLOT_W'(in_slot_index);
      probes_r <= probes_nxt;
    end
    if (state_r == S_HASH_B) begin
      base_r <= mul_p[SLOT_W-1:0] ^ thr_r[SLOT_W-1:0];
    end
    if (state_r == S_HASH_C) begin
      base_r <= base_r ^ mul_p[SLOT_W-1:0];
      st_r   <= ST_DROPPED;
    end
    if (probe_done) begin
      st_r   <= probe_st;
      slot_r <= chk_slot;
      row_r  <= mem_rdata;
    end
    if (state_r == S_RD_CAP) begin
      st_r  <= ST_READ;
      row_r <= mem_rdata;
    end
    if (fin_go) begin
      out_status_r  <= st_r;
      out_samples_r <= samples_nxt;
      out_dropped_r <= dropped_nxt;
      unique case (st_r)
        ST_NEW: begin
          out_addr_r <= addr_r;
          out_call_r <= call_r;
          out_thr_r  <= thr_r;
          out_cnt_r  <= 32'd1;
        end
        ST_COUNTED: begin
          out_addr_r <= row_r.address;
          out_call_r <= row_r.caller;
          out_thr_r  <= row_r.thread;
          out_cnt_r  <= cnt_inc;
        end
        ST_DROPPED: begin
          out_addr_r <= '0;
          out_call_r <= '0;
          out_thr_r  <= '0;
          out_cnt_r  <= '0;
        end
        ST_READ: begin
          // empty slot reads back as all zero
          if (row_r.count != 32'd0) begin
            out_addr_r <= row_r.address;
            out_call_r <= row_r.caller;
            out_thr_r  <= row_r.thread;
          end else begin
            out_addr_r <= '0;
            out_call_r <= '0;
            out_thr_r  <= '0;
          end
          out_cnt_r <= row_r.count;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_address = out_addr_r;
  assign out_entry_caller  = out_call_r;
  assign out_entry_thread  = out_thr_r;
  assign out_entry_count   = out_cnt_r;
  assign out_total_samples = out_samples_r;
  assign out_total_dropped = out_dropped_r;

endmodule

// ===== hdl/sample_triple_count_table_top.sv =====
`timescale 1ns / 1ps
// Hash-table histogram of (address, caller, thread) triples with linear probing.
// After reset the block runs a clearing pass over the slot memory, one slot per
// cycle (SLOTS slots, 4096 by default), with in_ch.ready low; configuration
// writes are taken during it. SLOTS must be a power of two. A read item reads
// its slot and captures the row before the update. A record item is hashed in
// S_HASH_A, S_HASH_B and S_HASH_C through the one shared 32x32 multiplier, then
// probed with one slot read per cycle from the single-read-port slot memory,
// each check in the cycle after its read, until its triple is found or placed
// at probe P (1 to 32) or dropped after N probes, then updated; with a probe
// limit of zero it goes from hash to update. One item is in work at a time;
// the next is accepted once the result register holds the previous result.
// depends on stct_pkg, stct_in_if, stct_out_if, stct_cfg, stct_mul,
// stct_store, stct_seq

module sample_triple_count_table_top #(
  parameter int SLOTS = stct_pkg::SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stct_in_if.sink                     in_ch,
  stct_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stct_pkg::CFG_AW-1:0] paddr,
  input  logic [stct_pkg::CFG_DW-1:0] pwdata,
  output logic [stct_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import stct_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  cfg_t              cfg;
  logic              mul_en;
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [31:0]       mul_p;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  row_t              mem_rdata;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  row_t              mem_wdata;

  stct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  stct_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  stct_store #(.SLOTS(SLOTS)) u_store (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  stct_seq #(.SLOTS(SLOTS)) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_operation      (in_ch.operation),
    .in_address        (in_ch.address),
    .in_caller         (in_ch.caller),
    .in_thread         (in_ch.thread),
    .in_slot_index     (in_ch.slot_index),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_entry_address (out_ch.entry_address),
    .out_entry_caller  (out_ch.entry_caller),
    .out_entry_thread  (out_ch.entry_thread),
    .out_entry_count   (out_ch.entry_count),
    .out_total_samples (out_ch.total_samples),
    .out_total_dropped (out_ch.total_dropped),
    .mul_en            (mul_en),
    .mul_a             (mul_a),
    .mul_b             (mul_b),
    .mul_p             (mul_p),
    .mem_re            (mem_re),
    .mem_raddr         (mem_raddr),
    .mem_rdata         (mem_rdata),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata)
  );

`ifndef SYNTHESIS
  // one item at a time: a transfer in closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input still ready right after a transfer");

  a_new_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_NEW) |-> (out_ch.entry_count == 32'd1))
    else $error("new slot result without a count of one");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_COUNTED) |->
      (out_ch.entry_count > 32'd1) && (out_ch.total_samples != 32'd0))
    else $error("counted result with an impossible count");

  a_dropped_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status == ST_DROPPED) |->
      (out_ch.entry_count == 32'd0) && (out_ch.total_dropped != 32'd0))
    else $error("dropped result carries slot data or no drop count");
`endif

endmodule
